@@ rtl/csd_pkg.sv @@
// Package for the column-slice dispatcher: field widths, function codes,
// per-slice counter word and configuration types.
// No dependencies; used by every other file of the block.
package csd_pkg;

  // Field widths of the item channels
  localparam int FUNC_W   = 3;
  localparam int ROW_W    = 16;
  localparam int COL_W    = 12;
  localparam int SLICE_W  = 4;
  localparam int VAL_W    = 31;
  localparam int POS_W    = 20;
  localparam int ROWTOT_W = 17;
  localparam int NZTOT_W  = 21;

  // Defaults of the top-level storage parameters
  localparam int MAX_COLUMNS_DEF = 4096;
  localparam int MAX_SLICES_DEF  = 16;

  // Counter saturation limits
  localparam logic [ROWTOT_W-1:0] ROWS_LIMIT = ROWTOT_W'(65536);
  localparam logic [NZTOT_W-1:0]  NZ_LIMIT   = NZTOT_W'(1048576);

  // Last-row marker meaning no row seen yet
  localparam logic [ROWTOT_W-1:0] NONE_SEEN = ROWTOT_W'(17'h10000);

  // Function codes of an input item
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_MAP   = 3'd0,
    FUNC_LOAD_START = 3'd1,
    FUNC_NONZERO    = 3'd2,
    FUNC_TOTALS     = 3'd3,
    FUNC_CLEAR      = 3'd4
  } func_t;

  // Result kinds
  localparam logic KIND_ENTRY  = 1'b0;
  localparam logic KIND_TOTALS = 1'b1;

  // Per-slice counter word, kept in one memory entry
  typedef struct packed {
    logic [ROWTOT_W-1:0] last_row;
    logic [ROWTOT_W-1:0] rows;
    logic [NZTOT_W-1:0]  nz;
  } cnt_t;

  localparam cnt_t CNT_RESET = '{last_row: NONE_SEEN, rows: '0, nz: '0};

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-3:0] REG_KEEP_VALUES = '0;

  typedef struct packed {
    logic keep_values;
  } cfg_t;

endpackage

@@ rtl/csd_in_if.sv @@
// Input item channel of the column-slice dispatcher: valid/ready plus payload.
// Depends on csd_pkg for field widths.
interface csd_in_if;
  logic                        valid;
  logic                        ready;
  logic [csd_pkg::FUNC_W-1:0]  func;
  logic [csd_pkg::ROW_W-1:0]   row;
  logic [csd_pkg::COL_W-1:0]   column;
  logic [csd_pkg::SLICE_W-1:0] slice;
  logic [csd_pkg::COL_W-1:0]   start_column;
  logic [csd_pkg::VAL_W-1:0]   value;

  modport source (output valid, func, row, column, slice, start_column, value,
                  input ready);
  modport sink (input valid, func, row, column, slice, start_column, value,
                output ready);
endinterface

@@ rtl/csd_out_if.sv @@
// Result item channel of the column-slice dispatcher: valid/ready plus payload.
// Depends on csd_pkg for field widths.
interface csd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [csd_pkg::SLICE_W-1:0]  out_slice;
  logic [csd_pkg::COL_W-1:0]    local_column;
  logic [csd_pkg::VAL_W-1:0]    out_value;
  logic [csd_pkg::ROW_W-1:0]    slice_row;
  logic [csd_pkg::ROW_W-1:0]    source_row;
  logic                         new_row;
  logic [csd_pkg::POS_W-1:0]    position;
  logic [csd_pkg::ROWTOT_W-1:0] row_total;
  logic [csd_pkg::NZTOT_W-1:0]  nz_total;

  modport source (output valid, kind, out_slice, local_column, out_value, slice_row,
                  source_row, new_row, position, row_total, nz_total,
                  input ready);
  modport sink (input valid, kind, out_slice, local_column, out_value, slice_row,
                source_row, new_row, position, row_total, nz_total,
                output ready);
endinterface

@@ rtl/csd_apb_regs.sv @@
// APB-style configuration registers of the column-slice dispatcher.
// Depends on csd_pkg for the address map and the cfg_t struct.
module csd_apb_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [csd_pkg::CFG_AW-1:0]  paddr,
  input  logic [csd_pkg::CFG_DW-1:0]  pwdata,
  output logic [csd_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output csd_pkg::cfg_t               cfg
);

  csd_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic          sel_keep;

  assign pready   = 1'b1;
  assign sel_keep = (paddr[csd_pkg::CFG_AW-1:2] == csd_pkg::REG_KEEP_VALUES);
  assign wr_en    = psel && penable && pwrite && pready;

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.keep_values <= 1'b1;
    end else if (wr_en && sel_keep) begin
      cfg_r.keep_values <= pwdata[0];
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    if (sel_keep) begin
      prdata[0] = cfg_r.keep_values;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/csr_column_slice_dispatch.sv @@
// Top level of the column-slice dispatcher: column map, slice start table and
// per-slice counter memory with read-modify-write and forwarding.
// Depends on csd_pkg, csd_in_if, csd_out_if and csd_apb_regs.
//
//   channel   | direction | handshake             | carries
//   ----------+-----------+-----------------------+------------------------------
//   in_if     | in        | valid/ready           | func, row, column, slice, ...
//   out_if    | out       | valid/ready           | dispatched entry or totals
//   psel/...  | in/out    | APB setup then access | keep_values register
//
// One item is accepted per cycle unless the output stalls; a result passes through
// the map read, counter/start read and output registers. The counter memory takes
// one read-modify-write per cycle unless stalled, with the previous write forwarded.
// Reset is synchronous; the counter valid bits clear at once, no sweep.
// A stalled output holds the whole pipeline; the output register lets a new
// item enter whenever the waiting result is taken in the same cycle.
module csr_column_slice_dispatch #(
  parameter int MAX_COLUMNS = csd_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_SLICES  = csd_pkg::MAX_SLICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  csd_in_if.sink                      in_if,
  csd_out_if.source                   out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [csd_pkg::CFG_AW-1:0]  paddr,
  input  logic [csd_pkg::CFG_DW-1:0]  pwdata,
  output logic [csd_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  // Column and slice fields bound the reachable depth
  localparam int COL_SPAN  = 1 << csd_pkg::COL_W;
  localparam int SL_SPAN   = 1 << csd_pkg::SLICE_W;
  localparam int MAP_DEPTH = (MAX_COLUMNS < COL_SPAN) ? MAX_COLUMNS : COL_SPAN;
  localparam int SL_DEPTH  = (MAX_SLICES < SL_SPAN) ? MAX_SLICES : SL_SPAN;
  localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int SL_AW     = (SL_DEPTH > 1) ? $clog2(SL_DEPTH) : 1;
  localparam logic [csd_pkg::COL_W:0]   MAP_LIM = (csd_pkg::COL_W + 1)'(MAP_DEPTH);
  localparam logic [csd_pkg::SLICE_W:0] SL_LIM  = (csd_pkg::SLICE_W + 1)'(SL_DEPTH);

  csd_pkg::cfg_t cfg;

  csd_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Memories
  logic [csd_pkg::SLICE_W-1:0] map_mem   [MAP_DEPTH];
  logic [csd_pkg::COL_W-1:0]   start_mem [SL_DEPTH];
  csd_pkg::cnt_t               cnt_mem   [SL_DEPTH];
  logic [SL_DEPTH-1:0]         cnt_vld_r;

  // Pipeline control
  logic adv;
  logic acc;
  logic out_valid_r;

  assign adv         = !out_valid_r || out_if.ready;
  assign in_if.ready = adv;
  assign acc         = in_if.valid && adv;

  // ---------------- accept stage: map and start writes, map read ----------------
  logic               col_ok;
  logic               sl_in_ok;
  logic [MAP_AW-1:0]  col_idx;
  logic [SL_AW-1:0]   sl_in_idx;
  logic               s1_valid_nxt;

  assign col_ok    = {1'b0, in_if.column} < MAP_LIM;
  assign sl_in_ok  = {1'b0, in_if.slice} < SL_LIM;
  assign col_idx   = in_if.column[MAP_AW-1:0];
  assign sl_in_idx = in_if.slice[SL_AW-1:0];

  always_comb begin
    s1_valid_nxt = 1'b0;
    if (acc) begin
      case (in_if.func)
        csd_pkg::FUNC_NONZERO: s1_valid_nxt = col_ok;
        csd_pkg::FUNC_TOTALS:  s1_valid_nxt = 1'b1;
        csd_pkg::FUNC_CLEAR:   s1_valid_nxt = 1'b1;
        default:               s1_valid_nxt = 1'b0;
      endcase
    end
  end

  logic [csd_pkg::SLICE_W-1:0] map_rd_r;

  // Write the column map on a load, read it for every item
  always_ff @(posedge clk) begin
    if (acc && (in_if.func == csd_pkg::FUNC_LOAD_MAP) && col_ok && sl_in_ok) begin
      map_mem[col_idx] <= in_if.slice;
    end
    if (adv) begin
      map_rd_r <= map_mem[col_idx];
    end
  end

  // Write the slice start table on a load
  always_ff @(posedge clk) begin
    if (acc && (in_if.func == csd_pkg::FUNC_LOAD_START) && sl_in_ok) begin
      start_mem[sl_in_idx] <= in_if.start_column;
    end
  end

  // Stage 1 registers
  logic                        s1_valid_r;
  csd_pkg::func_t              s1_func_r;
  logic [csd_pkg::ROW_W-1:0]   s1_row_r;
  logic [csd_pkg::COL_W-1:0]   s1_col_r;
  logic [csd_pkg::SLICE_W-1:0] s1_slice_r;
  logic [csd_pkg::VAL_W-1:0]   s1_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_func_r  <= csd_pkg::func_t'(in_if.func);
      s1_row_r   <= in_if.row;
      s1_col_r   <= in_if.column;
      s1_slice_r <= in_if.slice;
      s1_value_r <= in_if.value;
    end
  end

  // ---------------- stage 1: resolve slice, read counters and start ----------------
  logic [csd_pkg::SLICE_W-1:0] s1_k;
  logic                        s1_k_ok;
  logic [SL_AW-1:0]            s1_idx;
  logic                        s2_valid_nxt;

  assign s1_k         = (s1_func_r == csd_pkg::FUNC_NONZERO) ? map_rd_r : s1_slice_r;
  assign s1_k_ok      = {1'b0, s1_k} < SL_LIM;
  assign s1_idx       = s1_k[SL_AW-1:0];
  assign s2_valid_nxt = s1_valid_r && ((s1_func_r != csd_pkg::FUNC_NONZERO) || s1_k_ok);

  csd_pkg::cnt_t             cnt_rd_r;
  logic                      vld_rd_r;
  logic [csd_pkg::COL_W-1:0] start_rd_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      cnt_rd_r   <= cnt_mem[s1_idx];
      vld_rd_r   <= cnt_vld_r[s1_idx];
      start_rd_r <= start_mem[s1_idx];
    end
  end

  // Stage 2 registers
  logic                        s2_valid_r;
  csd_pkg::func_t              s2_func_r;
  logic [csd_pkg::SLICE_W-1:0] s2_slice_r;
  logic                        s2_ok_r;
  logic [SL_AW-1:0]            s2_idx_r;
  logic [csd_pkg::ROW_W-1:0]   s2_row_r;
  logic [csd_pkg::COL_W-1:0]   s2_col_r;
  logic [csd_pkg::VAL_W-1:0]   s2_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_func_r  <= s1_func_r;
      s2_slice_r <= s1_k;
      s2_ok_r    <= s1_k_ok;
      s2_idx_r   <= s1_idx;
      s2_row_r   <= s1_row_r;
      s2_col_r   <= s1_col_r;
      s2_value_r <= s1_value_r;
    end
  end

  // ---------------- stage 2: update counters, build result ----------------
  logic                        fwd_v_r;
  logic                        clr_fwd_r;
  logic [SL_AW-1:0]            fwd_idx_r;
  csd_pkg::cnt_t               fwd_word_r;
  csd_pkg::cnt_t               cur;
  csd_pkg::cnt_t               upd;
  logic                        fresh;
  logic                        cnt_wr;
  logic                        cnt_clr;
  logic [csd_pkg::ROWTOT_W-1:0] srow_full;
  logic [csd_pkg::NZTOT_W-1:0]  pos_full;

  assign cnt_wr  = adv && s2_valid_r && (s2_func_r == csd_pkg::FUNC_NONZERO);
  assign cnt_clr = adv && s2_valid_r && (s2_func_r == csd_pkg::FUNC_CLEAR);

  // Pick the newest counter word: clear, then last write, then memory
  always_comb begin
    if (clr_fwd_r) begin
      cur = csd_pkg::CNT_RESET;
    end else if (fwd_v_r && (fwd_idx_r == s2_idx_r)) begin
      cur = fwd_word_r;
    end else if (vld_rd_r) begin
      cur = cnt_rd_r;
    end else begin
      cur = csd_pkg::CNT_RESET;
    end
  end

  // Advance row and nonzero counts with saturation
  always_comb begin
    fresh = (cur.last_row != {1'b0, s2_row_r});
    upd   = cur;
    if (fresh) begin
      upd.last_row = {1'b0, s2_row_r};
      if (cur.rows < csd_pkg::ROWS_LIMIT) begin
        upd.rows = cur.rows + 1'b1;
      end
    end
    if (cur.nz < csd_pkg::NZ_LIMIT) begin
      upd.nz = cur.nz + 1'b1;
    end
    srow_full = upd.rows - 1'b1;
    pos_full  = (cur.nz > (csd_pkg::NZ_LIMIT - 1'b1)) ? (csd_pkg::NZ_LIMIT - 1'b1) : cur.nz;
  end

  // Write back the counter word
  always_ff @(posedge clk) begin
    if (cnt_wr) begin
      cnt_mem[s2_idx_r] <= upd;
    end
  end

  // Entry valid bits: a clear drops them all at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
    end else if (cnt_clr) begin
      cnt_vld_r <= '0;
    end else if (cnt_wr) begin
      cnt_vld_r[s2_idx_r] <= 1'b1;
    end
  end

  // Hold the write that lands with the next read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r   <= 1'b0;
      clr_fwd_r <= 1'b0;
    end else if (adv) begin
      fwd_v_r   <= cnt_wr;
      clr_fwd_r <= cnt_clr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_idx_r  <= s2_idx_r;
      fwd_word_r <= upd;
    end
  end

  // ---------------- output register ----------------
  logic                          res_valid;
  logic                          kind_r;
  logic [csd_pkg::SLICE_W-1:0]   slice_r;
  logic [csd_pkg::COL_W-1:0]     local_r;
  logic [csd_pkg::VAL_W-1:0]     value_r;
  logic [csd_pkg::ROW_W-1:0]     srow_r;
  logic [csd_pkg::ROW_W-1:0]     src_row_r;
  logic                          new_row_r;
  logic [csd_pkg::POS_W-1:0]     pos_r;
  logic [csd_pkg::ROWTOT_W-1:0]  row_tot_r;
  logic [csd_pkg::NZTOT_W-1:0]   nz_tot_r;

  assign res_valid = s2_valid_r && ((s2_func_r == csd_pkg::FUNC_NONZERO) ||
                                    (s2_func_r == csd_pkg::FUNC_TOTALS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      slice_r <= s2_slice_r;
      if (s2_func_r == csd_pkg::FUNC_TOTALS) begin
        kind_r    <= csd_pkg::KIND_TOTALS;
        local_r   <= '0;
        value_r   <= '0;
        srow_r    <= '0;
        src_row_r <= '0;
        new_row_r <= 1'b0;
        pos_r     <= '0;
        row_tot_r <= s2_ok_r ? cur.rows : '0;
        nz_tot_r  <= s2_ok_r ? cur.nz : '0;
      end else begin
        kind_r    <= csd_pkg::KIND_ENTRY;
        local_r   <= s2_col_r - start_rd_r;
        value_r   <= cfg.keep_values ? s2_value_r : '0;
        srow_r    <= srow_full[csd_pkg::ROW_W-1:0];
        src_row_r <= fresh ? s2_row_r : '0;
        new_row_r <= fresh;
        pos_r     <= pos_full[csd_pkg::POS_W-1:0];
        row_tot_r <= upd.rows;
        nz_tot_r  <= upd.nz;
      end
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.kind         = kind_r;
  assign out_if.out_slice    = slice_r;
  assign out_if.local_column = local_r;
  assign out_if.out_value    = value_r;
  assign out_if.slice_row    = srow_r;
  assign out_if.source_row   = src_row_r;
  assign out_if.new_row      = new_row_r;
  assign out_if.position     = pos_r;
  assign out_if.row_total    = row_tot_r;
  assign out_if.nz_total     = nz_tot_r;

endmodule
